### design/bdq_pkg.sv
// Shared types, codes and widths of the bounded deque core.
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int DATA_W = 32;
  localparam int ACT_W = 3;
  localparam int POS_W = 9;
  localparam int STAT_W = 2;

  // Operation codes carried by the action field.
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_READ       = 3'd2,
    ACT_WRITE      = 3'd3,
    ACT_FIND       = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_t;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // One finished result, handed from the sequencer to the output stage.
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         item_total;
  } res_t;

endpackage

### design/bdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/bdq_ctrl.sv
// Sequencer of the deque: ring pointers, memory accesses, find scan and result build.
module bdq_ctrl
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         action,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] data_value,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_t                     res,
  output logic                     ram_we,
  output logic [$clog2(DEPTH)-1:0] ram_waddr,
  output logic [DATA_W-1:0]        ram_wdata,
  output logic                     ram_re,
  output logic [$clog2(DEPTH)-1:0] ram_raddr,
  input  logic [DATA_W-1:0]        ram_rdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {S_IDLE, S_RD_WAIT, S_SCAN, S_DONE} state_t;

  state_t          state;
  logic [IW-1:0]   front;
  logic [CW-1:0]   count;
  logic [DATA_W-1:0] key;
  logic [IW-1:0]   scan_slot;
  logic [CW-1:0]   issue_off;
  logic [CW-1:0]   cmp_off;
  logic            cmp_valid;

  action_t         act;
  logic            acc;
  logic            full;
  logic [PW-1:0]   pos_ext;
  logic [PW-1:0]   pos_off;
  logic            pos_bad;
  logic [IW:0]     sum_rw;
  logic [IW-1:0]   slot_rw;
  logic [IW:0]     sum_bk;
  logic [IW-1:0]   slot_bk;
  logic [IW-1:0]   front_dec;
  logic [CW-1:0]   count_inc;
  logic            issuing;
  logic            match;

  // Narrows a count or position to the nine-bit result fields.
  function automatic logic [POS_W-1:0] to_total(input logic [CW-1:0] x);
    logic [PW-1:0] v;
    v = PW'(x);
    return v[POS_W-1:0];
  endfunction

  assign act      = action_t'(action);
  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign full     = (count == CW'(DEPTH));
  assign count_inc = count + CW'(1);

  // Position check and ring slot of a 1-based position.
  assign pos_ext = PW'(position);
  assign pos_off = pos_ext - PW'(1);
  assign pos_bad = (pos_ext == '0) || (pos_ext > PW'(count));
  assign sum_rw  = {1'b0, front} + {1'b0, pos_off[IW-1:0]};
  assign slot_rw = (sum_rw >= (IW+1)'(DEPTH)) ? IW'(sum_rw - (IW+1)'(DEPTH)) : sum_rw[IW-1:0];

  // Slot just past the back, and slot just before the front.
  assign sum_bk    = {1'b0, front} + {1'b0, count[IW-1:0]};
  assign slot_bk   = (sum_bk >= (IW+1)'(DEPTH)) ? IW'(sum_bk - (IW+1)'(DEPTH)) : sum_bk[IW-1:0];
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);

  // Find scan: one read issued per cycle, each compared with the key when its registered read data returns.
  assign issuing = (state == S_SCAN) && (issue_off != count);
  assign match   = cmp_valid && (ram_rdata == key);

  // Memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_rw;
    if (acc) begin
      unique case (act)
        ACT_PUSH_FRONT: begin
          ram_we    = !full;
          ram_waddr = front_dec;
        end
        ACT_PUSH_BACK: begin
          ram_we    = !full;
          ram_waddr = slot_bk;
        end
        ACT_WRITE: ram_we = !pos_bad;
        default: ram_we = 1'b0;
      endcase
    end
  end

  assign ram_wdata = data_value;
  assign ram_re    = (acc && (act == ACT_READ) && !pos_bad) || issuing;
  assign ram_raddr = (state == S_SCAN) ? scan_slot : slot_rw;
  assign res_valid = (state == S_DONE);

  // State, ring pointers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            res.status         <= ST_OK;
            res.read_value     <= '0;
            res.found_position <= '0;
            res.item_total     <= to_total(count);
            state              <= S_DONE;
            unique case (act)
              ACT_PUSH_FRONT: begin
                if (full) begin
                  res.status <= ST_FULL;
                end else begin
                  front          <= front_dec;
                  count          <= count_inc;
                  res.item_total <= to_total(count_inc);
                end
              end
              ACT_PUSH_BACK: begin
                if (full) begin
                  res.status <= ST_FULL;
                end else begin
                  count          <= count_inc;
                  res.item_total <= to_total(count_inc);
                end
              end
              ACT_READ: begin
                if (pos_bad) begin
                  res.status <= ST_BADPOS;
                end else begin
                  state <= S_RD_WAIT;
                end
              end
              ACT_WRITE: begin
                if (pos_bad) begin
                  res.status <= ST_BADPOS;
                end
              end
              ACT_FIND: begin
                res.status <= ST_NOTFOUND;
                if (count != '0) begin
                  key       <= data_value;
                  scan_slot <= front;
                  issue_off <= '0;
                  cmp_valid <= 1'b0;
                  state     <= S_SCAN;
                end
              end
              ACT_CLEAR: begin
                front          <= '0;
                count          <= '0;
                res.item_total <= '0;
              end
              default: res.status <= ST_OK;
            endcase
          end
        end
        S_RD_WAIT: begin
          res.read_value <= ram_rdata;
          state          <= S_DONE;
        end
        S_SCAN: begin
          cmp_valid <= issuing;
          if (issuing) begin
            scan_slot <= (scan_slot == IW'(DEPTH - 1)) ? '0 : scan_slot + IW'(1);
            issue_off <= issue_off + CW'(1);
            cmp_off   <= issue_off;
          end
          if (match) begin
            res.status         <= ST_OK;
            res.found_position <= to_total(cmp_off + CW'(1));
            cmp_valid          <= 1'b0;
            state              <= S_DONE;
          end else if (!issuing && !cmp_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The count never passes the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stored count exceeds depth");

  // The front index stays inside the ring.
  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front <= IW'(DEPTH - 1))
    else $error("front index outside the ring");

  // No store is written while a find is scanning.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ram_we)
    else $error("memory write during find scan");

  // A successful push at the back grows the count by exactly one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (acc && (act == ACT_PUSH_BACK) && !full) |=> (count == $past(count) + CW'(1)))
    else $error("push did not grow the count by one");

endmodule

### design/bounded_deque_indexed_core.sv
// Bounded double-ended queue of signed 32-bit values, indexed access and find.
// Values sit in a ring held in one synchronous RAM of DEPTH entries, described by a
// front index and a count. One item is worked at a time; the result goes to an output
// register, so the next beat can be taken while a finished result waits downstream.
// Push, write, clear and rejected operations go from acceptance to the done state, and
// back to idle once the output register takes the result; a read passes a wait state
// first for the RAM's registered read, and a find scans the stored items, one RAM entry
// per cycle, until a match or the end. The store needs no clearing after reset.
module bounded_deque_indexed_core
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         action,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] data_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] read_value,
  output logic [POS_W-1:0]         found_position,
  output logic [POS_W-1:0]         item_total
);

  localparam int IW = $clog2(DEPTH);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_res;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  bdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .position  (position),
    .data_value(data_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Output register: takes a result when empty or when its beat leaves this cycle.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign status         = out_res.status;
  assign read_value     = out_res.read_value;
  assign found_position = out_res.found_position;
  assign item_total     = out_res.item_total;

endmodule

### dv/testbench.sv
// Self-checking testbench for the bounded deque core, with scoreboard and stimulus.
module testbench;
  import bdq_pkg::*;

  localparam int QDEPTH = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT = 1500000;
  // A find over a full ring is the slowest operation, so the final wait covers it.
  localparam int SETTLE_CYCLES = 300;
  localparam int REPORT_CAP = 20;
  // Action codes with no operation behind them.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  // Ring model of the deque together with the list of results still to arrive.
  class deque_ledger;
    logic signed [DATA_W-1:0] slots [QDEPTH];
    logic [7:0] head;
    int unsigned total;
    res_t awaited_q [$];
    int errors;

    function new();
      head = '0;
      total = 0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    // Applies one accepted operation and queues the result it must produce.
    function void apply_op(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
      res_t r;
      int unsigned i;
      r = '0;
      r.status = ST_OK;
      case (act)
        ACT_PUSH_FRONT: begin
          if (total >= QDEPTH) begin
            r.status = ST_FULL;
          end else begin
            head = head - 8'd1;
            slots[head] = val;
            total++;
          end
        end
        ACT_PUSH_BACK: begin
          if (total >= QDEPTH) begin
            r.status = ST_FULL;
          end else begin
            slots[8'(head + total)] = val;
            total++;
          end
        end
        ACT_READ: begin
          if (pos == '0 || pos > total) r.status = ST_BADPOS;
          else r.read_value = slots[8'(head + pos - 1)];
        end
        ACT_WRITE: begin
          if (pos == '0 || pos > total) r.status = ST_BADPOS;
          else slots[8'(head + pos - 1)] = val;
        end
        ACT_FIND: begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < total; i++) begin
            if (slots[8'(head + i)] == val) begin
              r.status = ST_OK;
              r.found_position = POS_W'(i + 1);
              break;
            end
          end
        end
        ACT_CLEAR: begin
          total = 0;
          head = '0;
        end
        default: begin
        end
      endcase
      r.item_total = POS_W'(total);
      awaited_q.push_back(r);
    endfunction

    function void report(string field, longint exp_v, longint got_v);
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    endfunction

    // Compares one accepted result beat with the oldest queued result.
    function void check_result(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] rd,
                               logic [POS_W-1:0] fp, logic [POS_W-1:0] tot);
      res_t e;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result beat with nothing expected, status %0d total %0d",
                   $time, st, tot);
        return;
      end
      e = awaited_q.pop_front();
      if (st !== e.status) report("status", e.status, st);
      if (rd !== e.read_value) report("read_value", e.read_value, rd);
      if (fp !== e.found_position) report("found_position", e.found_position, fp);
      if (tot !== e.item_total) report("item_total", e.item_total, tot);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACT_W-1:0] action = '0;
  logic [POS_W-1:0] position = '0;
  logic signed [DATA_W-1:0] data_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic signed [DATA_W-1:0] read_value;
  logic [POS_W-1:0] found_position;
  logic [POS_W-1:0] item_total;

  deque_ledger ledger = new();
  int cycle_count = 0;

  // Sender-side view of the fill level and of recently stored values.
  int shadow_total = 0;
  logic [DATA_W-1:0] seen_vals [16];
  int seen_wr = 0;
  int items_sent = 0;

  bounded_deque_indexed_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .position       (position),
    .data_value     (data_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .item_total     (item_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge; the input beat is logged first.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) ledger.apply_op(action, position, data_value);
      if (out_valid && out_ready)
        ledger.check_result(status, read_value, found_position, item_total);
    end
  end

  // Receiver: changing stall patterns, plus long hold-offs that back the block up.
  initial begin : receiver
    int hold_left;
    int mode;
    int phase_left;
    int rx_cycles;
    hold_left = 0;
    mode = 0;
    phase_left = 0;
    rx_cycles = 0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles == 1500 || rx_cycles == 9000) hold_left = 700;
      if (phase_left == 0) begin
        mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_cycles % 3 != 0);
        endcase
      end
    end
  end

  // Presents one beat and waits for it to be taken; call right after a rising edge.
  task automatic send_op(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val);
    action <= act;
    position <= pos;
    data_value <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    case (act) inside
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_total < QDEPTH) begin
          shadow_total++;
          seen_vals[seen_wr] = val;
          seen_wr = (seen_wr + 1) % 16;
        end
      end
      ACT_WRITE: begin
        if (pos != 0 && pos <= shadow_total) begin
          seen_vals[seen_wr] = val;
          seen_wr = (seen_wr + 1) % 16;
        end
      end
      ACT_CLEAR: shadow_total = 0;
      default: begin
      end
    endcase
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (r <= 3) return DATA_W'($urandom_range(0, 15)) - 32'd4;
    if (r <= 5) return seen_vals[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return POS_W'(shadow_total + 1);
    if (r == 2) return POS_W'($urandom_range(0, 511));
    if (shadow_total == 0) return POS_W'($urandom_range(0, 511));
    return POS_W'($urandom_range(1, shadow_total));
  endfunction

  // Draws one operation with the given push share and clear rate in thousandths.
  task automatic random_op(input int push_pct, input int clear_pm);
    int r;
    logic [DATA_W-1:0] v;
    r = $urandom_range(0, 999);
    if (r < clear_pm) begin
      send_op(ACT_CLEAR, POS_W'($urandom_range(0, 511)), $urandom);
    end else if (r < clear_pm + 10) begin
      send_op(($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI,
              pick_position(), pick_value());
    end else begin
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        send_op(($urandom_range(0, 1) == 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                POS_W'($urandom_range(0, 511)), pick_value());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          send_op(ACT_READ, pick_position(), pick_value());
        end else if (r < 65) begin
          send_op(ACT_WRITE, pick_position(), pick_value());
        end else begin
          v = ($urandom_range(0, 4) < 3) ? seen_vals[$urandom_range(0, 15)] : pick_value();
          send_op(ACT_FIND, pick_position(), v);
        end
      end
    end
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  int burst_left = 0;
  bit gapless = 1'b0;

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gapless = ($urandom_range(0, 3) == 0);
      if (!gapless) pause(($urandom_range(0, 4) == 0) ? $urandom_range(4, 16)
                                                      : $urandom_range(0, 3));
    end
    burst_left--;
  endtask

  initial begin : stimulus
    int ep;
    int extra;
    int len;
    int push_pct;
    foreach (seen_vals[i]) seen_vals[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-queue cases, extreme values, front wrap, bad positions, spare codes.
    send_op(ACT_READ, 9'd1, 32'd0);
    send_op(ACT_FIND, 9'd0, 32'd0);
    send_op(ACT_WRITE, 9'd1, 32'd9);
    send_op(ACT_PUSH_BACK, 9'd0, 32'h7fff_ffff);
    send_op(ACT_PUSH_FRONT, 9'd0, 32'h8000_0000);
    send_op(ACT_PUSH_BACK, 9'd0, 32'hffff_ffff);
    send_op(ACT_PUSH_FRONT, 9'd511, 32'h0000_0000);
    send_op(ACT_READ, 9'd1, 32'd0);
    send_op(ACT_READ, 9'd4, 32'd0);
    send_op(ACT_READ, 9'd0, 32'd0);
    send_op(ACT_READ, 9'd5, 32'd0);
    send_op(ACT_READ, 9'd511, 32'hffff_ffff);
    send_op(ACT_WRITE, 9'd2, 32'h5555_5555);
    send_op(ACT_WRITE, 9'd4, 32'haaaa_aaaa);
    send_op(ACT_WRITE, 9'd0, 32'h1234_5678);
    send_op(ACT_WRITE, 9'd256, 32'h1234_5678);
    send_op(ACT_FIND, 9'd0, 32'haaaa_aaaa);
    send_op(ACT_FIND, 9'd0, 32'h7fff_ffff);
    send_op(ACT_FIND, 9'd0, 32'h0001_2345);
    send_op(ACT_SPARE_LO, 9'd1, 32'd7);
    send_op(ACT_SPARE_HI, 9'd511, 32'hffff_ffff);
    send_op(ACT_CLEAR, 9'd0, 32'd0);
    send_op(ACT_READ, 9'd1, 32'd0);
    send_op(ACT_PUSH_FRONT, 9'd0, 32'd5);
    send_op(ACT_READ, 9'd1, 32'd0);

    // Random: episodes that fill the ring to full, and mixed episodes at lower levels.
    items_sent = 0;
    ep = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (ep == 0 || $urandom_range(0, 3) == 0) begin
        while (shadow_total < QDEPTH) begin
          pace();
          random_op(85, 0);
        end
        extra = $urandom_range(15, 40);
        repeat (extra) begin
          pace();
          random_op(50, 0);
        end
        pace();
        send_op(ACT_CLEAR, POS_W'($urandom_range(0, 511)), $urandom);
      end else begin
        len = $urandom_range(40, 200);
        push_pct = $urandom_range(30, 60);
        repeat (len) begin
          pace();
          random_op(push_pct, 5);
        end
        if ($urandom_range(0, 1) == 0) begin
          pace();
          send_op(ACT_CLEAR, POS_W'($urandom_range(0, 511)), $urandom);
        end
      end
      ep++;
    end
    in_valid <= 1'b0;

    // One more edge so that the last input beat is logged, then drain the
    // outstanding results and watch for stray beats.
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
design/bdq_pkg.sv
design/bdq_ram.sv
design/bdq_ctrl.sv
design/bounded_deque_indexed_core.sv
dv/testbench.sv
